>>> src/ihp_pkg.sv
// Shared types, codes and default sizes for the indexed min-heap.
// No dependencies; used by indexed_min_heap_top and the bench tb.
package ihp_pkg;

  localparam int unsigned CAPACITY_DEF     = 1024;
  localparam int unsigned HANDLE_COUNT_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF     = 32;

  // Fixed field widths of the stream words
  localparam int unsigned TAG_W  = 24;
  localparam int unsigned HDL_W  = 10;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned IKEY_W = 32;

  typedef enum logic [2:0] {
    CMD_INSERT     = 3'd0,
    CMD_REMOVE_MIN = 3'd1,
    CMD_REPLACE    = 3'd2,
    CMD_DELETE_AT  = 3'd3,
    CMD_CHANGE     = 3'd4,
    CMD_CHANGE_KEY = 3'd5,
    CMD_READ_AT    = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

>>> src/ihp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ihp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/indexed_min_heap_top.sv
// Indexed binary min-heap: one entry RAM, one handle-position RAM, a sequencer
// with several key comparators. Depends on ihp_pkg and ihp_ram.
// Read, clear and failing commands finish without sifting; a sift up moves one
// level per step and a sift down one level per step, reading both children
// through the one RAM read port. The next word is taken only after the result
// is loaded, so one command is in flight at a time.
// Reset (rst_n, synchronous) empties the heap; RAM contents are not cleared.
module indexed_min_heap_top #(
  parameter int unsigned CAPACITY     = ihp_pkg::CAPACITY_DEF,
  parameter int unsigned HANDLE_COUNT = ihp_pkg::HANDLE_COUNT_DEF,
  parameter int unsigned KEY_BITS     = ihp_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0], key[34:3], tag[58:35], handle[68:59], position[79:69]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_key[31:0], out_tag[55:32], out_handle[65:56], final_position[76:66],
  // heap_size[87:77], status[89:88], zero[95:90]
  output logic [95:0] out_tdata
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned HB = $clog2(HANDLE_COUNT);
  localparam int unsigned WW = (PW > ihp_pkg::POS_W) ? PW : ihp_pkg::POS_W;
  localparam int unsigned HW = (HB > ihp_pkg::HDL_W) ? HB + 1 : ihp_pkg::HDL_W + 1;
  localparam int unsigned EW = KEY_BITS + ihp_pkg::TAG_W + ihp_pkg::HDL_W;
  localparam logic [KEY_BITS-1:0] KSIGN = {1'b1, {(KEY_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_GOTTOP, S_GOTPOS, S_GOTLAST, S_UP_RD, S_UP_CMP,
    S_DN_RD1, S_DN_RD2, S_DN_CMP, S_WR, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  ihp_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [23:0]          tag_r, tag_nxt;
  logic [9:0]           hdl_r, hdl_nxt;
  logic [10:0]          pos_r, pos_nxt;
  logic [PW-1:0]        n_r, n_nxt, p_r, p_nxt, start_r, start_nxt, fp_r, fp_nxt;
  logic [EW-1:0]        mv_r, mv_nxt, c1_r, c1_nxt;
  logic                 dn_after_r, dn_after_nxt;
  logic [31:0]          rk_r, rk_nxt;
  logic [23:0]          rt_r, rt_nxt;
  logic [9:0]           rh_r, rh_nxt;
  ihp_pkg::status_t     st_r, st_nxt;
  logic                 ov_r, ov_nxt;
  logic [95:0]          od_r, od_nxt;

  logic                 we;
  logic [PW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata, child;
  logic [PW-1:0]        cpos;
  logic                 pwe;
  logic [HB-1:0]        paddr;

  logic signed [KEY_BITS-1:0] kin_s;
  logic [KEY_BITS-1:0]        key_in_b;
  logic                       pos_ok;

  ihp_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_entry (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  ihp_ram #(.WIDTH(PW), .DEPTH(HANDLE_COUNT)) u_pos (
    .clk, .we(pwe), .waddr(paddr), .wdata(waddr), .raddr(paddr), .rdata()
  );

  // Back from biased key to a 32-bit signed output key
  function automatic logic [31:0] key_out(input logic [KEY_BITS-1:0] b);
    logic signed [KEY_BITS-1:0] s;
    s = $signed(b ^ KSIGN);
    return 32'(s);
  endfunction

  // Bias the incoming key so unsigned order is signed order
  assign kin_s    = KEY_BITS'($signed(in_tdata[34:3]));
  assign key_in_b = kin_s ^ KSIGN;
  assign pos_ok   = (pos_r != '0) && (WW'(pos_r) <= WW'(n_r));

  // Position-table write goes with every entry write whose handle is below HANDLE_COUNT
  assign pwe   = we && (HW'(wdata[9:0]) < HW'(HANDLE_COUNT));
  assign paddr = HB'(wdata[9:0]);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // Read address per sequencer step
  always_comb begin
    case (state_r)
      S_DISP:   raddr = (cmd_r == ihp_pkg::CMD_REMOVE_MIN || cmd_r == ihp_pkg::CMD_REPLACE)
                        ? PW'(1) : PW'(pos_r);
      S_GOTPOS: raddr = n_r;
      S_UP_RD:  raddr = p_r >> 1;
      S_DN_RD1: raddr = PW'({p_r, 1'b0});
      S_DN_RD2: raddr = PW'({p_r, 1'b1});
      default:  raddr = '0;
    endcase
  end

  // Pick the smaller child (left on tie)
  always_comb begin
    child = c1_r;
    cpos  = PW'({p_r, 1'b0});
    if (cpos < n_r && c1_r[EW-1 -: KEY_BITS] > rdata[EW-1 -: KEY_BITS]) begin
      child = rdata;
      cpos  = PW'({p_r, 1'b1});
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; key_nxt = key_r; tag_nxt = tag_r;
    hdl_nxt = hdl_r; pos_nxt = pos_r; n_nxt = n_r; p_nxt = p_r;
    start_nxt = start_r; fp_nxt = fp_r; mv_nxt = mv_r; c1_nxt = c1_r;
    dn_after_nxt = dn_after_r; rk_nxt = rk_r; rt_nxt = rt_r; rh_nxt = rh_r;
    st_nxt = st_r; ov_nxt = ov_r; od_nxt = od_r;
    we = 1'b0; waddr = p_r; wdata = mv_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = ihp_pkg::cmd_t'(in_tdata[2:0]);
          key_nxt   = key_in_b;
          tag_nxt   = in_tdata[58:35];
          hdl_nxt   = in_tdata[68:59];
          pos_nxt   = in_tdata[79:69];
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        rk_nxt = '0; rt_nxt = '0; rh_nxt = '0; fp_nxt = '0;
        st_nxt = ihp_pkg::ST_OK; dn_after_nxt = 1'b0;
        mv_nxt = {key_r, tag_r, hdl_r};
        state_nxt = S_DONE;
        case (cmd_r)
          ihp_pkg::CMD_INSERT: begin
            if (n_r == PW'(CAPACITY)) begin
              st_nxt = ihp_pkg::ST_FULL;
            end else begin
              n_nxt = n_r + 1'b1; p_nxt = n_r + 1'b1; state_nxt = S_UP_RD;
            end
          end
          ihp_pkg::CMD_CLEAR: n_nxt = '0;
          ihp_pkg::CMD_REPLACE: begin
            if (n_r == '0) begin
              rk_nxt = key_out(key_r); rt_nxt = tag_r; rh_nxt = hdl_r;
              st_nxt = ihp_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_GOTTOP;
            end
          end
          default: begin
            if (n_r == '0) begin
              st_nxt = ihp_pkg::ST_EMPTY;
            end else if (cmd_r == ihp_pkg::CMD_REMOVE_MIN) begin
              p_nxt = PW'(1); state_nxt = S_GOTPOS;
            end else if (!pos_ok) begin
              st_nxt = ihp_pkg::ST_RANGE;
            end else begin
              p_nxt = PW'(pos_r); state_nxt = S_GOTPOS;
            end
          end
        endcase
      end
      S_GOTTOP: begin
        if (key_r < rdata[EW-1 -: KEY_BITS]) begin
          rk_nxt = key_out(rdata[EW-1 -: KEY_BITS]);
          rt_nxt = rdata[33:10]; rh_nxt = rdata[9:0];
          p_nxt = PW'(1); state_nxt = S_DN_RD1;
        end else begin
          rk_nxt = key_out(key_r); rt_nxt = tag_r; rh_nxt = hdl_r;
          state_nxt = S_DONE;
        end
      end
      S_GOTPOS: begin
        rk_nxt = key_out(rdata[EW-1 -: KEY_BITS]);
        rt_nxt = rdata[33:10]; rh_nxt = rdata[9:0];
        start_nxt = p_r;
        case (cmd_r)
          ihp_pkg::CMD_REMOVE_MIN, ihp_pkg::CMD_DELETE_AT: state_nxt = S_GOTLAST;
          ihp_pkg::CMD_CHANGE, ihp_pkg::CMD_CHANGE_KEY: begin
            if (cmd_r == ihp_pkg::CMD_CHANGE_KEY) mv_nxt = {key_r, rdata[33:0]};
            if (key_r == rdata[EW-1 -: KEY_BITS]) state_nxt = S_DONE;
            else if (key_r < rdata[EW-1 -: KEY_BITS]) state_nxt = S_UP_RD;
            else state_nxt = S_DN_RD1;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_GOTLAST: begin
        mv_nxt = rdata;
        n_nxt  = n_r - 1'b1;
        if (p_r >= n_r) begin
          // Removed the last entry itself: nothing to move
          state_nxt = S_DONE;
        end else begin
          dn_after_nxt = 1'b1; state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (p_r != PW'(1)) state_nxt = S_UP_CMP;
        else if (dn_after_r && p_r == start_r) begin
          dn_after_nxt = 1'b0; state_nxt = S_DN_RD1;
        end else state_nxt = S_WR;
      end
      S_UP_CMP: begin
        if (rdata[EW-1 -: KEY_BITS] > mv_r[EW-1 -: KEY_BITS]) begin
          // Move the parent down one level
          we = 1'b1; wdata = rdata;
          p_nxt = p_r >> 1; dn_after_nxt = 1'b0; state_nxt = S_UP_RD;
        end else if (dn_after_r) begin
          dn_after_nxt = 1'b0; state_nxt = S_DN_RD1;
        end else state_nxt = S_WR;
      end
      S_DN_RD1: state_nxt = (p_r <= (n_r >> 1)) ? S_DN_RD2 : S_WR;
      S_DN_RD2: begin
        c1_nxt = rdata; state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (mv_r[EW-1 -: KEY_BITS] <= child[EW-1 -: KEY_BITS]) begin
          state_nxt = S_WR;
        end else begin
          // Move the smaller child up one level
          we = 1'b1; wdata = child;
          p_nxt = cpos; state_nxt = S_DN_RD1;
        end
      end
      S_WR: begin
        we = 1'b1;
        if (cmd_r == ihp_pkg::CMD_INSERT) fp_nxt = p_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {6'd0, st_r, 11'(n_r), 11'(fp_r), rh_r, rt_r, rk_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, datapath and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      n_r        <= '0;
      ov_r       <= 1'b0;
      dn_after_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      ov_r       <= ov_nxt;
      dn_after_r <= dn_after_nxt;
    end
    cmd_r <= cmd_nxt; key_r <= key_nxt; tag_r <= tag_nxt; hdl_r <= hdl_nxt;
    pos_r <= pos_nxt; p_r <= p_nxt; start_r <= start_nxt; fp_r <= fp_nxt;
    mv_r <= mv_nxt; c1_r <= c1_nxt; rk_r <= rk_nxt; rt_r <= rt_nxt;
    rh_r <= rh_nxt; st_r <= st_nxt; od_r <= od_nxt;
  end

  // Heap never grows past its capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= PW'(CAPACITY)) else $error("heap count above capacity");

  // Entry writes land inside the one-based live range
  a_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (waddr != '0 && waddr <= n_r)) else $error("entry write out of range");

  // An accepted word closes the input until its result is loaded
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("accepted while busy");

  // A result is presented once the sequencer leaves S_DONE
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |=> out_tvalid)
    else $error("result not presented");

endmodule

>>> tb/tb.sv
// Self-checking bench for indexed_min_heap_top: directed and random heap commands
// against an in-bench heap predictor. Depends on ihp_pkg and the heap RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 1024;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [79:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;

  indexed_min_heap_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] heap_size;
    logic [10:0] final_pos;
    logic [9:0]  handle;
    logic [23:0] tag;
    logic [31:0] key;
  } heap_result_t;

  // predictor state, one-based
  logic signed [31:0] hp_key [1:CAP];
  logic [23:0] hp_tag [1:CAP];
  logic [9:0]  hp_hdl [1:CAP];
  logic [10:0] slot_of_handle [0:1023];
  int unsigned hp_count;

  logic [79:0] cmd_queue [$];
  heap_result_t result_queue [$];
  int unsigned error_count;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned stall_phase;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void place(int unsigned p, logic signed [31:0] k, logic [23:0] t,
                                logic [9:0] h);
    hp_key[p] = k;
    hp_tag[p] = t;
    hp_hdl[p] = h;
    slot_of_handle[h] = p[10:0];
  endfunction

  function automatic int unsigned bubble_up(int unsigned p);
    logic signed [31:0] k;
    logic [23:0] t;
    logic [9:0] h;
    k = hp_key[p]; t = hp_tag[p]; h = hp_hdl[p];
    while (p > 1 && hp_key[p/2] > k) begin
      place(p, hp_key[p/2], hp_tag[p/2], hp_hdl[p/2]);
      p = p / 2;
    end
    place(p, k, t, h);
    return p;
  endfunction

  function automatic void bubble_down(int unsigned p);
    logic signed [31:0] k;
    logic [23:0] t;
    logic [9:0] h;
    int unsigned c;
    k = hp_key[p]; t = hp_tag[p]; h = hp_hdl[p];
    while (p <= hp_count / 2) begin
      c = 2 * p;
      if (c < hp_count && hp_key[c] > hp_key[c+1]) c++;
      if (k <= hp_key[c]) break;
      place(p, hp_key[c], hp_tag[c], hp_hdl[c]);
      p = c;
    end
    place(p, k, t, h);
  endfunction

  // apply one command word to the predictor and return its result
  function automatic heap_result_t apply_command(logic [79:0] w);
    ihp_pkg::cmd_t cmd;
    logic signed [31:0] k;
    logic [23:0] t;
    logic [9:0] h;
    int unsigned pos;
    heap_result_t r;
    cmd = ihp_pkg::cmd_t'(w[2:0]);
    k = w[34:3]; t = w[58:35]; h = w[68:59]; pos = w[79:69];
    r = '0;
    r.status = ihp_pkg::ST_OK;
    if (cmd == ihp_pkg::CMD_INSERT) begin
      if (hp_count >= CAP) r.status = ihp_pkg::ST_FULL;
      else begin
        hp_count++;
        place(hp_count, k, t, h);
        r.final_pos = 11'(bubble_up(hp_count));
      end
    end else if (cmd == ihp_pkg::CMD_CLEAR) begin
      hp_count = 0;
    end else if (cmd == ihp_pkg::CMD_REPLACE) begin
      r.key = k; r.tag = t; r.handle = h;
      if (hp_count == 0) r.status = ihp_pkg::ST_EMPTY;
      else if (k < hp_key[1]) begin
        r.key = hp_key[1]; r.tag = hp_tag[1]; r.handle = hp_hdl[1];
        place(1, k, t, h);
        bubble_down(1);
      end
    end else if (hp_count == 0) begin
      r.status = ihp_pkg::ST_EMPTY;
    end else if (cmd != ihp_pkg::CMD_REMOVE_MIN && (pos == 0 || pos > hp_count)) begin
      r.status = ihp_pkg::ST_RANGE;
    end else begin
      if (cmd == ihp_pkg::CMD_REMOVE_MIN) pos = 1;
      r.key = hp_key[pos]; r.tag = hp_tag[pos]; r.handle = hp_hdl[pos];
      if (cmd == ihp_pkg::CMD_REMOVE_MIN || cmd == ihp_pkg::CMD_DELETE_AT) begin
        place(pos, hp_key[hp_count], hp_tag[hp_count], hp_hdl[hp_count]);
        hp_count--;
        if (pos <= hp_count && bubble_up(pos) == pos) bubble_down(pos);
      end else if (cmd == ihp_pkg::CMD_CHANGE || cmd == ihp_pkg::CMD_CHANGE_KEY) begin
        if (k != r.key) begin
          if (cmd == ihp_pkg::CMD_CHANGE) place(pos, k, t, h);
          else hp_key[pos] = k;
          if (k < $signed(r.key)) void'(bubble_up(pos));
          else bubble_down(pos);
        end
      end
    end
    r.heap_size = hp_count[10:0];
    return r;
  endfunction

  function automatic logic [79:0] pack_cmd(ihp_pkg::cmd_t c, logic [31:0] k,
                                           logic [23:0] t, logic [9:0] h,
                                           logic [10:0] p);
    return {p, h, t, k, c};
  endfunction

  // random key: mostly narrow so ties happen, sometimes full range
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [79:0] w;
    int unsigned fill;
    int unsigned sel;
    // extremes and special cases, starting on the empty heap
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_REMOVE_MIN, 0, 0, 0, 1));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_REPLACE, 32'h8000_0000, 24'hFFFFFF,
                                 10'h3FF, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_READ_AT, 0, 0, 0, 1));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_INSERT, 32'h7FFF_FFFF, 24'hFFFFFF,
                                 10'h3FF, 11'h7FF));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_INSERT, 32'h8000_0000, 24'h000001,
                                 10'h001, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_INSERT, 32'h0, 24'h000002, 10'h002, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_INSERT, 32'h0, 24'h000003, 10'h003, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_READ_AT, 0, 0, 0, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_READ_AT, 0, 0, 0, 11'h7FF));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_READ_AT, 0, 0, 0, 4));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_REPLACE, 32'h7FFF_FFFF, 24'h5, 10'h5, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_REPLACE, 32'h8000_0000, 24'h6, 10'h6, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_CHANGE, 32'h0, 24'hABCDEF, 10'h200, 3));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_CHANGE_KEY, 32'hFFFF_0000, 0, 0, 3));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_CHANGE, 32'h1000, 24'h7, 10'h7, 1));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_DELETE_AT, 0, 0, 0, 2));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_DELETE_AT, 0, 0, 0, 3));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_REMOVE_MIN, 0, 0, 0, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_CLEAR, 0, 0, 0, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_REMOVE_MIN, 0, 0, 0, 0));
    // fill to capacity once, hit full, then delete one entry and clear
    for (fill = 0; fill < CAP; fill++)
      cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_INSERT, pick_key(), 24'($urandom),
                                   10'($urandom), 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_INSERT, 0, 0, 0, 0));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_READ_AT, 0, 0, 0, 11'd1024));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_DELETE_AT, 0, 0, 0, 11'd1024));
    cmd_queue.push_back(pack_cmd(ihp_pkg::CMD_CLEAR, 0, 0, 0, 0));
    // random mix: mostly in-range positions on a small heap
    for (int i = 0; i < 300; i++) begin
      sel = $urandom_range(0, 99);
      w = pack_cmd(ihp_pkg::cmd_t'($urandom_range(0, 6)), pick_key(), 24'($urandom),
                   10'($urandom), 11'($urandom_range(1, 40)));
      if (sel < 30) w[2:0] = ihp_pkg::CMD_INSERT;
      else if (sel < 32) w[2:0] = ihp_pkg::CMD_CLEAR;
      else if (sel < 36) w[79:69] = 11'($urandom);
      cmd_queue.push_back(w);
    end
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: bursts with random gaps
  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    gap_left = 0;
    burst_left = 0;
    hp_count = 0;
    error_count = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // advance past an accepted word
      if (in_tvalid && in_tready) begin
        result_queue.push_back(apply_command(in_tdata));
        void'(cmd_queue.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= cmd_queue[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
        end else burst_left <= burst_left - 1;
      end else in_tvalid <= 1'b0;
    end
  end

  // receiver stall pattern
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 256) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 9) != 0) && (stall_phase % 7 != 0);
    endcase
  end
  initial stall_phase = 0;

  // monitor
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[89:0];
      if (result_queue.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        error_count++;
      end else begin
        want = result_queue.pop_front();
        if (got.key !== want.key) begin
          $error("out_key exp %h got %h", want.key, got.key); error_count++;
        end
        if (got.tag !== want.tag) begin
          $error("out_tag exp %h got %h", want.tag, got.tag); error_count++;
        end
        if (got.handle !== want.handle) begin
          $error("out_handle exp %h got %h", want.handle, got.handle); error_count++;
        end
        if (got.final_pos !== want.final_pos) begin
          $error("final_position exp %0d got %0d", want.final_pos, got.final_pos);
          error_count++;
        end
        if (got.heap_size !== want.heap_size) begin
          $error("heap_size exp %0d got %0d", want.heap_size, got.heap_size);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); error_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    wait (cmd_queue.size() == 0 && !in_tvalid);
    wait (result_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end
endmodule
